/* rtl/core/rrts_pkg.sv */
`timescale 1ns / 1ps

package rrts_pkg;

    localparam int ID_W    = 4;
    localparam int NUM_IDS = 1 << ID_W;
    localparam int COUNT_W = 5;
    localparam int UPC_W   = 4;

    typedef logic [UPC_W-1:0] upc_t;
    typedef logic [ID_W-1:0]  id_t;

    localparam logic [2:0] ACT_ATTACH    = 3'd0;
    localparam logic [2:0] ACT_DECIDE    = 3'd1;
    localparam logic [2:0] ACT_BLOCK_DEC = 3'd2;
    localparam logic [2:0] ACT_BLOCK     = 3'd3;
    localparam logic [2:0] ACT_UNBLOCK   = 3'd4;
    localparam logic [2:0] ACT_HALT      = 3'd5;
    localparam logic [2:0] ACT_PREPARE   = 3'd6;
    localparam logic [2:0] ACT_DISPATCH  = 3'd7;

    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_NO_READY  = 2'd1;
    localparam logic [1:0] ERR_FULL      = 2'd2;
    localparam logic [1:0] ERR_NOT_FOUND = 2'd3;

    localparam upc_t UPC_FETCH     = 4'd0;
    localparam upc_t UPC_ATTACH    = 4'd1;
    localparam upc_t UPC_BLOCK     = 4'd2;
    localparam upc_t UPC_BLOCK_DEC = 4'd3;
    localparam upc_t UPC_UNBLOCK   = 4'd4;
    localparam upc_t UPC_PREPARE   = 4'd5;
    localparam upc_t UPC_DISPATCH  = 4'd6;
    localparam upc_t UPC_DEC_CHK   = 4'd7;
    localparam upc_t UPC_DEC_TST   = 4'd8;
    localparam upc_t UPC_HALT_CHK  = 4'd9;
    localparam upc_t UPC_HALT_TST  = 4'd10;
    localparam upc_t UPC_DONE      = 4'd11;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_ATTACH,
        OP_CLR_READY,
        OP_SET_READY,
        OP_PREPARE,
        OP_DISPATCH,
        OP_DEC_CHK,
        OP_DEC_TST,
        OP_HALT_CHK,
        OP_HALT_TST,
        OP_EMIT
    } uop_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_DISPATCH,
        C_SCAN_END,
        C_HIT_READY,
        C_HIT_ID,
        C_OUT_FREE
    } cond_t;

    typedef struct packed {
        uop_t  uop;
        cond_t cond;
        upc_t  t_true;
        upc_t  t_false;
    } ctrl_word_t;

    typedef struct packed {
        logic scan_end;
        logic hit_ready;
        logic hit_id;
        logic out_free;
    } flags_t;

endpackage

/* rtl/core/rrts_sequencer.sv */
`timescale 1ns / 1ps

module rrts_sequencer
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [2:0]     action,
    input  rrts_pkg::flags_t flags,
    output rrts_pkg::uop_t uop,
    output logic           in_stall
);
    import rrts_pkg::*;

    upc_t       upc_reg;
    upc_t       upc_next;
    ctrl_word_t cw;
    logic       take;

    function automatic ctrl_word_t ucode(input upc_t a);
        ctrl_word_t w;
        begin
            w = '{OP_IDLE, C_DISPATCH, UPC_FETCH, UPC_FETCH};
            case (a)
                UPC_FETCH:     w = '{OP_IDLE,      C_DISPATCH,  UPC_FETCH,    UPC_FETCH};
                UPC_ATTACH:    w = '{OP_ATTACH,    C_ALWAYS,    UPC_DONE,     UPC_DONE};
                UPC_BLOCK:     w = '{OP_CLR_READY, C_ALWAYS,    UPC_DONE,     UPC_DONE};
                UPC_BLOCK_DEC: w = '{OP_CLR_READY, C_ALWAYS,    UPC_DEC_CHK,  UPC_DEC_CHK};
                UPC_UNBLOCK:   w = '{OP_SET_READY, C_ALWAYS,    UPC_DONE,     UPC_DONE};
                UPC_PREPARE:   w = '{OP_PREPARE,   C_ALWAYS,    UPC_DONE,     UPC_DONE};
                UPC_DISPATCH:  w = '{OP_DISPATCH,  C_ALWAYS,    UPC_DONE,     UPC_DONE};
                UPC_DEC_CHK:   w = '{OP_DEC_CHK,   C_SCAN_END,  UPC_DONE,     UPC_DEC_TST};
                UPC_DEC_TST:   w = '{OP_DEC_TST,   C_HIT_READY, UPC_DONE,     UPC_DEC_CHK};
                UPC_HALT_CHK:  w = '{OP_HALT_CHK,  C_SCAN_END,  UPC_DONE,     UPC_HALT_TST};
                UPC_HALT_TST:  w = '{OP_HALT_TST,  C_HIT_ID,    UPC_DEC_CHK,  UPC_HALT_CHK};
                UPC_DONE:      w = '{OP_EMIT,      C_OUT_FREE,  UPC_FETCH,    UPC_DONE};
                default:       w = '{OP_IDLE,      C_DISPATCH,  UPC_FETCH,    UPC_FETCH};
            endcase
            return w;
        end
    endfunction

    function automatic upc_t entry(input logic [2:0] act);
        upc_t e;
        begin
            e = UPC_DISPATCH;
            case (act)
                ACT_ATTACH:    e = UPC_ATTACH;
                ACT_DECIDE:    e = UPC_DEC_CHK;
                ACT_BLOCK_DEC: e = UPC_BLOCK_DEC;
                ACT_BLOCK:     e = UPC_BLOCK;
                ACT_UNBLOCK:   e = UPC_UNBLOCK;
                ACT_HALT:      e = UPC_HALT_CHK;
                ACT_PREPARE:   e = UPC_PREPARE;
                ACT_DISPATCH:  e = UPC_DISPATCH;
                default:       e = UPC_DISPATCH;
            endcase
            return e;
        end
    endfunction

    assign cw       = ucode(upc_reg);
    assign uop      = cw.uop;
    assign in_stall = (upc_reg != UPC_FETCH);

    always_comb
    begin
        take = 1'b0;
        case (cw.cond)
            C_ALWAYS:    take = 1'b1;
            C_DISPATCH:  take = in_valid;
            C_SCAN_END:  take = flags.scan_end;
            C_HIT_READY: take = flags.hit_ready;
            C_HIT_ID:    take = flags.hit_id;
            C_OUT_FREE:  take = flags.out_free;
            default:     take = 1'b0;
        endcase
        if (cw.cond == C_DISPATCH)
        begin
            upc_next = take ? entry(action) : cw.t_false;
        end
        else
        begin
            upc_next = take ? cw.t_true : cw.t_false;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= UPC_FETCH;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

/* rtl/core/rrts_datapath.sv */
`timescale 1ns / 1ps

module rrts_datapath
#(
    parameter int MAX_THREADS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  rrts_pkg::uop_t               uop,
    input  logic                         in_valid,
    input  logic [rrts_pkg::ID_W-1:0]    thread_id,
    input  logic [rrts_pkg::ID_W-1:0]    parent_id,
    input  logic                         start_running,
    input  logic                         cancel,
    input  logic                         nested,
    output rrts_pkg::flags_t             flags,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         pending_valid,
    output logic [rrts_pkg::ID_W-1:0]    pending_id,
    output logic                         do_switch,
    output logic [rrts_pkg::ID_W-1:0]    switch_id,
    output logic [1:0]                   error,
    output logic [rrts_pkg::COUNT_W-1:0] ring_count
);
    import rrts_pkg::*;

    localparam int IW = $clog2(MAX_THREADS);
    localparam int FW = $clog2(MAX_THREADS + 1);
    localparam int SW = FW + 1;

    id_t              ring_mem [MAX_THREADS];
    id_t              rd_data_reg;

    logic [NUM_IDS-1:0] ready_reg;
    logic [IW-1:0]    head_reg;
    logic [FW-1:0]    fill_reg;
    logic [FW-1:0]    cnt_reg;
    logic             pend_flag_reg;
    id_t              pend_id_reg;
    logic             run_flag_reg;
    id_t              run_id_reg;
    logic [1:0]       err_reg;
    logic             sw_reg;
    id_t              sw_id_reg;

    id_t              tid_reg;
    id_t              pid_reg;
    logic             start_reg;
    logic             cancel_reg;
    logic             nested_reg;

    logic             out_valid_reg;
    logic             pend_valid_out_reg;
    id_t              pend_id_out_reg;
    logic             sw_out_reg;
    id_t              sw_id_out_reg;
    logic [1:0]       err_out_reg;
    logic [COUNT_W-1:0] count_out_reg;

    logic             accept;
    logic             full;
    logic             emit;
    logic             can_switch;
    logic [IW-1:0]    head_inc;
    logic [SW-1:0]    tail_sum;
    logic [IW-1:0]    tail;
    logic             wr_en;
    id_t              wr_data;

    assign accept   = (uop == OP_IDLE) && in_valid;
    assign full     = (fill_reg >= FW'(MAX_THREADS));
    assign head_inc = (head_reg == IW'(MAX_THREADS - 1)) ? '0 : head_reg + 1'b1;
    assign tail_sum = SW'(head_reg) + SW'(fill_reg);
    assign tail     = (tail_sum >= SW'(MAX_THREADS)) ? IW'(tail_sum - SW'(MAX_THREADS))
                                                    : IW'(tail_sum);

    assign flags.scan_end  = (cnt_reg == fill_reg);
    assign flags.hit_ready = ready_reg[rd_data_reg];
    assign flags.hit_id    = (rd_data_reg == tid_reg);
    assign flags.out_free  = !out_valid_reg || !out_stall;

    assign emit       = (uop == OP_EMIT) && flags.out_free;
    assign can_switch = !nested_reg && pend_flag_reg &&
                        !(run_flag_reg && (run_id_reg == pend_id_reg));

    assign wr_en   = ((uop == OP_ATTACH) && !full) || (uop == OP_DEC_TST) ||
                     ((uop == OP_HALT_TST) && !flags.hit_id);
    assign wr_data = (uop == OP_ATTACH) ? tid_reg : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[tail] <= wr_data;
        end
        rd_data_reg <= ring_mem[head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tid_reg    <= thread_id;
            pid_reg    <= parent_id;
            start_reg  <= start_running;
            cancel_reg <= cancel;
            nested_reg <= nested;
        end
        if (emit)
        begin
            pend_valid_out_reg <= pend_flag_reg;
            pend_id_out_reg    <= pend_flag_reg ? pend_id_reg : '0;
            sw_out_reg         <= sw_reg;
            sw_id_out_reg      <= sw_id_reg;
            err_out_reg        <= err_reg;
            count_out_reg      <= COUNT_W'(fill_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg     <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            pend_flag_reg <= 1'b0;
            pend_id_reg   <= '0;
            run_flag_reg  <= 1'b0;
            run_id_reg    <= '0;
            err_reg       <= ERR_OK;
            sw_reg        <= 1'b0;
            sw_id_reg     <= '0;
        end
        else
        begin
            case (uop)
                OP_IDLE:
                begin
                    if (accept)
                    begin
                        cnt_reg   <= '0;
                        err_reg   <= ERR_OK;
                        sw_reg    <= 1'b0;
                        sw_id_reg <= '0;
                    end
                end
                OP_ATTACH:
                begin
                    if (full)
                    begin
                        err_reg <= ERR_FULL;
                    end
                    else
                    begin
                        ready_reg[tid_reg] <= start_reg;
                        fill_reg           <= fill_reg + 1'b1;
                    end
                end
                OP_CLR_READY:
                begin
                    ready_reg[tid_reg] <= 1'b0;
                end
                OP_SET_READY:
                begin
                    ready_reg[tid_reg] <= 1'b1;
                end
                OP_PREPARE:
                begin
                    if (cancel_reg)
                    begin
                        pend_flag_reg <= 1'b0;
                    end
                    else
                    begin
                        pend_flag_reg <= 1'b1;
                        pend_id_reg   <= tid_reg;
                    end
                end
                OP_DISPATCH:
                begin
                    if (can_switch)
                    begin
                        run_flag_reg  <= 1'b1;
                        run_id_reg    <= pend_id_reg;
                        pend_flag_reg <= 1'b0;
                        sw_reg        <= 1'b1;
                        sw_id_reg     <= pend_id_reg;
                    end
                end
                OP_DEC_CHK:
                begin
                    if (flags.scan_end)
                    begin
                        err_reg <= ERR_NO_READY;
                    end
                end
                OP_DEC_TST:
                begin
                    // front entry goes to the tail either way
                    head_reg <= head_inc;
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (flags.hit_ready)
                    begin
                        pend_flag_reg <= 1'b1;
                        pend_id_reg   <= rd_data_reg;
                    end
                end
                OP_HALT_CHK:
                begin
                    if (flags.scan_end)
                    begin
                        err_reg <= ERR_NOT_FOUND;
                    end
                end
                OP_HALT_TST:
                begin
                    head_reg <= head_inc;
                    if (flags.hit_id)
                    begin
                        fill_reg           <= fill_reg - 1'b1;
                        ready_reg[pid_reg] <= 1'b1;
                        cnt_reg            <= '0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pending_valid = pend_valid_out_reg;
    assign pending_id    = pend_id_out_reg;
    assign do_switch     = sw_out_reg;
    assign switch_id     = sw_id_out_reg;
    assign error         = err_out_reg;
    assign ring_count    = count_out_reg;

endmodule

/* rtl/core/round_robin_thread_scheduler.sv */
`timescale 1ns / 1ps

// Round-robin thread scheduler.
// Input channel: in_valid / in_stall with action, thread_id, parent_id,
// start_running, cancel and nested. One result item per input item on
// out_valid / out_stall: pending_valid, pending_id, do_switch, switch_id,
// error and ring_count, all taken after the item's effects.
// One item at a time, run by a microcoded step sequencer. A decision walks
// the ring one entry per two steps (memory read, then test and rotate) until
// it finds a ready entry or has passed all entries with none ready. Halt
// first runs its own search for the target, then, if found, the decision.
// in_stall is high from the accept until the result is placed in the
// output register; a new item is accepted while that result waits.
// If out_stall holds the output register full, the sequencer waits at its
// last step and in_stall stays high.
// Reset empties the ring, clears all ready bits, the pending target and the
// running thread. The ring memory is not cleared; no pass is needed.

module round_robin_thread_scheduler
#(
    parameter int MAX_THREADS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [2:0]                   action,
    input  logic [rrts_pkg::ID_W-1:0]    thread_id,
    input  logic [rrts_pkg::ID_W-1:0]    parent_id,
    input  logic                         start_running,
    input  logic                         cancel,
    input  logic                         nested,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         pending_valid,
    output logic [rrts_pkg::ID_W-1:0]    pending_id,
    output logic                         do_switch,
    output logic [rrts_pkg::ID_W-1:0]    switch_id,
    output logic [1:0]                   error,
    output logic [rrts_pkg::COUNT_W-1:0] ring_count
);
    import rrts_pkg::*;

    uop_t   uop;
    flags_t flags;

    rrts_sequencer u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .flags    (flags),
        .uop      (uop),
        .in_stall (in_stall)
    );

    rrts_datapath #(.MAX_THREADS(MAX_THREADS)) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .uop           (uop),
        .in_valid      (in_valid),
        .thread_id     (thread_id),
        .parent_id     (parent_id),
        .start_running (start_running),
        .cancel        (cancel),
        .nested        (nested),
        .flags         (flags),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pending_valid (pending_valid),
        .pending_id    (pending_id),
        .do_switch     (do_switch),
        .switch_id     (switch_id),
        .error         (error),
        .ring_count    (ring_count)
    );

endmodule

/* rtl/core/rrts_checker.sv */
`timescale 1ns / 1ps

module rrts_checker
#(
    parameter int MAX_THREADS = 16
)
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic                         pending_valid,
    input logic [rrts_pkg::ID_W-1:0]    pending_id,
    input logic                         do_switch,
    input logic [1:0]                   error,
    input logic [rrts_pkg::COUNT_W-1:0] ring_count
);
    import rrts_pkg::*;

    // one item at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("item accepted while previous one still in work");

    a_pending_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !pending_valid) |-> (pending_id == '0))
        else $error("pending_id nonzero with nothing pending");

    a_switch_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && do_switch) |-> (!pending_valid && (error == ERR_OK)))
        else $error("committed switch left a target pending or flagged an error");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((MAX_THREADS >= 32) || (ring_count <= COUNT_W'(MAX_THREADS))))
        else $error("ring_count above ring depth");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(ring_count) && $stable(error)))
        else $error("stalled result changed");

endmodule

bind round_robin_thread_scheduler rrts_checker #(.MAX_THREADS(MAX_THREADS)) u_rrts_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pending_valid (pending_valid),
    .pending_id    (pending_id),
    .do_switch     (do_switch),
    .error         (error),
    .ring_count    (ring_count)
);

/* tb/round_robin_thread_scheduler_tb.sv */
`timescale 1ns / 1ps

module round_robin_thread_scheduler_tb;

    import rrts_pkg::*;

    localparam int MAX_THREADS    = 16;
    localparam int DIR_ROWS       = 23;
    localparam int RAND_PER_PHASE = 138;
    localparam int SETTLE_CYCLES  = 100;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int EXP_DEPTH      = 16;

    typedef struct packed {
        logic [2:0] act;
        id_t        tid;
        id_t        par;
        logic       start;
        logic       cancel_req;
        logic       nest;
    } sched_cmd_t;

    typedef struct packed {
        logic                pv;
        id_t                 pid;
        logic                sw;
        id_t                 swid;
        logic [1:0]          err;
        logic [COUNT_W-1:0]  cnt;
    } sched_status_t;

    typedef struct {
        sched_cmd_t    cmd;
        int            reps;
        logic          chk;
        sched_status_t res;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         action;
    id_t                thread_id;
    id_t                parent_id;
    logic               start_running;
    logic               cancel;
    logic               nested;
    logic               out_valid;
    logic               out_stall;
    logic               pending_valid;
    id_t                pending_id;
    logic               do_switch;
    id_t                switch_id;
    logic [1:0]         error;
    logic [COUNT_W-1:0] ring_count;

    int send_idle_pct = 25;
    int recv_idle_pct = 84;
    int fail_cnt = 0;
    int cycle_cnt = 0;

    // expected results, in order of acceptance
    sched_status_t exp_buf [EXP_DEPTH];
    int            exp_wr = 0;
    int            exp_rd = 0;
    dir_row_t      dir_tab [DIR_ROWS];

    // scheduler state mirror
    id_t                sch_ring [MAX_THREADS];
    logic [15:0]        sch_ready = '0;
    logic [3:0]         sch_head = '0;
    logic [COUNT_W-1:0] sch_fill = '0;
    logic               sch_pend = 1'b0;
    id_t                sch_pend_id = '0;
    logic               sch_run = 1'b0;
    id_t                sch_run_id = '0;

    round_robin_thread_scheduler #(
        .MAX_THREADS(MAX_THREADS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .thread_id(thread_id),
        .parent_id(parent_id),
        .start_running(start_running),
        .cancel(cancel),
        .nested(nested),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .pending_valid(pending_valid),
        .pending_id(pending_id),
        .do_switch(do_switch),
        .switch_id(switch_id),
        .error(error),
        .ring_count(ring_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic sched_cmd_t mk_cmd(input logic [2:0] act, input int tid, input int par,
                                          input int start, input int cnl, input int nst);
        sched_cmd_t c;
        c.act        = act;
        c.tid        = ID_W'(tid);
        c.par        = ID_W'(par);
        c.start      = 1'(start);
        c.cancel_req = 1'(cnl);
        c.nest       = 1'(nst);
        return c;
    endfunction

    function automatic sched_status_t mk_res(input int pv, input int pid, input int sw,
                                             input int swid, input logic [1:0] err,
                                             input int cnt);
        sched_status_t r;
        r.pv   = 1'(pv);
        r.pid  = ID_W'(pid);
        r.sw   = 1'(sw);
        r.swid = ID_W'(swid);
        r.err  = err;
        r.cnt  = COUNT_W'(cnt);
        return r;
    endfunction

    // front entry moves to the tail
    function automatic void ring_rotate();
        id_t v;
        if (sch_fill == 0)
            return;
        v = sch_ring[sch_head];
        sch_ring[4'(sch_head + sch_fill)] = v;
        sch_head = sch_head + 1'b1;
    endfunction

    function automatic logic [1:0] ring_decide();
        int k;
        k = 0;
        while (k < sch_fill && !sch_ready[sch_ring[4'(sch_head + k)]])
            k++;
        if (k >= sch_fill)
            return ERR_NO_READY;
        sch_pend_id = sch_ring[4'(sch_head + k)];
        sch_pend    = 1'b1;
        repeat (k + 1) ring_rotate();
        return ERR_OK;
    endfunction

    function automatic sched_status_t schedule_step(input sched_cmd_t c);
        sched_status_t r;
        int            k;
        r = '0;
        case (c.act)
            ACT_ATTACH:
            begin
                if (sch_fill >= MAX_THREADS)
                    r.err = ERR_FULL;
                else
                begin
                    sch_ready[c.tid] = c.start;
                    sch_ring[4'(sch_head + sch_fill)] = c.tid;
                    sch_fill = sch_fill + 1'b1;
                end
            end
            ACT_DECIDE:
                r.err = ring_decide();
            ACT_BLOCK_DEC:
            begin
                sch_ready[c.tid] = 1'b0;
                r.err = ring_decide();
            end
            ACT_BLOCK:
                sch_ready[c.tid] = 1'b0;
            ACT_UNBLOCK:
                sch_ready[c.tid] = 1'b1;
            ACT_HALT:
            begin
                k = 0;
                while (k < sch_fill && sch_ring[4'(sch_head + k)] != c.tid)
                    k++;
                if (k >= sch_fill)
                    r.err = ERR_NOT_FOUND;
                else
                begin
                    repeat (k) ring_rotate();
                    sch_head = sch_head + 1'b1;
                    sch_fill = sch_fill - 1'b1;
                    sch_ready[c.par] = 1'b1;
                    r.err = ring_decide();
                end
            end
            ACT_PREPARE:
            begin
                if (c.cancel_req)
                    sch_pend = 1'b0;
                else
                begin
                    sch_pend    = 1'b1;
                    sch_pend_id = c.tid;
                end
            end
            default:
            begin
                if (!c.nest && sch_pend && !(sch_run && sch_run_id == sch_pend_id))
                begin
                    sch_run    = 1'b1;
                    sch_run_id = sch_pend_id;
                    sch_pend   = 1'b0;
                    r.sw       = 1'b1;
                    r.swid     = sch_run_id;
                end
            end
        endcase
        r.pv  = sch_pend;
        r.pid = sch_pend ? sch_pend_id : '0;
        r.cnt = sch_fill;
        return r;
    endfunction

    // mostly acts on threads that sit in the ring; the rest is noise
    function automatic sched_cmd_t rand_cmd(input int attach_w);
        sched_cmd_t c;
        c.tid        = 4'($urandom);
        c.par        = 4'($urandom);
        c.start      = 1'($urandom);
        c.cancel_req = 1'($urandom);
        c.nest       = 1'($urandom);
        if ($urandom_range(0, 99) < attach_w)
            c.act = ACT_ATTACH;
        else
            c.act = 3'($urandom_range(1, 7));
        if (c.act != ACT_ATTACH && c.act != ACT_PREPARE && sch_fill != 0
            && $urandom_range(0, 3) != 0)
            c.tid = sch_ring[4'(sch_head + $urandom_range(0, sch_fill - 1))];
        return c;
    endfunction

    task automatic send_item(input sched_cmd_t c, input logic chk, input sched_status_t typed);
        sched_status_t r;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        action        <= c.act;
        thread_id     <= c.tid;
        parent_id     <= c.par;
        start_running <= c.start;
        cancel        <= c.cancel_req;
        nested        <= c.nest;
        do
            @(posedge clk);
        while (in_stall);
        r = schedule_step(c);
        exp_buf[exp_wr % EXP_DEPTH] = chk ? typed : r;
        exp_wr++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (exp_wr != exp_rd);
    endtask

    task automatic check_field(input string fname, input int exp_v, input int got_v);
        if (exp_v != got_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, exp_v, got_v);
            fail_cnt++;
        end
    endtask

    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : monitor
        sched_status_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (exp_wr == exp_rd)
            begin
                $display("%0t: result with none expected, actual err %0d count %0d",
                         $time, error, ring_count);
                fail_cnt++;
            end
            else
            begin
                e = exp_buf[exp_rd % EXP_DEPTH];
                exp_rd++;
                check_field("pending_valid", int'(e.pv), int'(pending_valid));
                check_field("pending_id", int'(e.pid), int'(pending_id));
                check_field("do_switch", int'(e.sw), int'(do_switch));
                check_field("switch_id", int'(e.swid), int'(switch_id));
                check_field("error", int'(e.err), int'(error));
                check_field("ring_count", int'(e.cnt), int'(ring_count));
            end
        end
    end

    initial
    begin : stim
        sched_cmd_t    rc;
        sched_status_t no_res;
        int            attach_w;
        no_res        = '0;
        in_valid      <= 1'b0;
        action        <= ACT_ATTACH;
        thread_id     <= '0;
        parent_id     <= '0;
        start_running <= 1'b0;
        cancel        <= 1'b0;
        nested        <= 1'b0;

        dir_tab = '{
            '{mk_cmd(ACT_DECIDE, 9, 3, 1, 1, 1), 1, 1'b1, mk_res(0, 0, 0, 0, ERR_NO_READY, 0)},
            '{mk_cmd(ACT_DISPATCH, 15, 15, 1, 1, 0), 1, 1'b1, mk_res(0, 0, 0, 0, ERR_OK, 0)},
            '{mk_cmd(ACT_HALT, 5, 15, 0, 0, 0), 1, 1'b1, mk_res(0, 0, 0, 0, ERR_NOT_FOUND, 0)},
            '{mk_cmd(ACT_ATTACH, 0, 15, 1, 1, 1), 1, 1'b1, mk_res(0, 0, 0, 0, ERR_OK, 1)},
            '{mk_cmd(ACT_ATTACH, 15, 0, 0, 0, 0), 1, 1'b1, mk_res(0, 0, 0, 0, ERR_OK, 2)},
            '{mk_cmd(ACT_ATTACH, 15, 0, 1, 0, 0), 1, 1'b1, mk_res(0, 0, 0, 0, ERR_OK, 3)},
            '{mk_cmd(ACT_DECIDE, 0, 0, 0, 0, 0), 1, 1'b1, mk_res(1, 0, 0, 0, ERR_OK, 3)},
            '{mk_cmd(ACT_DISPATCH, 0, 0, 0, 0, 1), 1, 1'b1, mk_res(1, 0, 0, 0, ERR_OK, 3)},
            '{mk_cmd(ACT_DISPATCH, 0, 0, 0, 0, 0), 1, 1'b1, mk_res(0, 0, 1, 0, ERR_OK, 3)},
            '{mk_cmd(ACT_PREPARE, 0, 0, 0, 0, 0), 1, 1'b1, mk_res(1, 0, 0, 0, ERR_OK, 3)},
            '{mk_cmd(ACT_DISPATCH, 0, 0, 0, 0, 0), 1, 1'b1, mk_res(1, 0, 0, 0, ERR_OK, 3)},
            '{mk_cmd(ACT_PREPARE, 9, 0, 0, 1, 0), 1, 1'b1, mk_res(0, 0, 0, 0, ERR_OK, 3)},
            '{mk_cmd(ACT_BLOCK, 15, 0, 1, 0, 0), 1, 1'b0, no_res},
            '{mk_cmd(ACT_BLOCK_DEC, 0, 0, 0, 0, 0), 1, 1'b1, mk_res(0, 0, 0, 0, ERR_NO_READY, 3)},
            '{mk_cmd(ACT_UNBLOCK, 15, 0, 0, 0, 0), 1, 1'b0, no_res},
            '{mk_cmd(ACT_HALT, 15, 0, 0, 0, 0), 1, 1'b0, no_res},
            '{mk_cmd(ACT_ATTACH, 7, 0, 0, 0, 0), 14, 1'b0, no_res},
            '{mk_cmd(ACT_ATTACH, 3, 0, 1, 0, 0), 1, 1'b1, mk_res(1, 15, 0, 0, ERR_FULL, 16)},
            '{mk_cmd(ACT_BLOCK, 0, 0, 0, 0, 0), 1, 1'b0, no_res},
            '{mk_cmd(ACT_BLOCK, 15, 0, 0, 0, 0), 1, 1'b0, no_res},
            '{mk_cmd(ACT_DECIDE, 0, 0, 0, 0, 0), 1, 1'b1, mk_res(1, 15, 0, 0, ERR_NO_READY, 16)},
            '{mk_cmd(ACT_HALT, 7, 7, 0, 0, 0), 1, 1'b0, no_res},
            '{mk_cmd(ACT_DISPATCH, 0, 0, 0, 0, 0), 1, 1'b0, no_res}
        };

        do
            @(posedge clk);
        while (!rst_n);

        for (int i = 0; i < DIR_ROWS; i++)
            repeat (dir_tab[i].reps) send_item(dir_tab[i].cmd, dir_tab[i].chk, dir_tab[i].res);
        drain_results();

        // fill-heavy, then drain-heavy, then balanced
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 84 : 0;
            recv_idle_pct = (ph == 0) ? 84 : (ph == 1) ? 25 : 0;
            attach_w      = (ph == 0) ? 35 : (ph == 1) ? 10 : 22;
            repeat (RAND_PER_PHASE)
            begin
                rc = rand_cmd(attach_w);
                send_item(rc, 1'b0, no_res);
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
